// ===== src/motor_status_frame_parser_defines.svh =====
// ---------------------------------------------------------------------------
// Motor status frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle during reset.
// ---------------------------------------------------------------------------
`ifndef MOTOR_STATUS_FRAME_PARSER_DEFINES_SVH
`define MOTOR_STATUS_FRAME_PARSER_DEFINES_SVH

// The property must hold in the same cycle as the condition.
`define MSFP_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("%m: assertion failed");

// The property must hold in the cycle after the condition.
`define MSFP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: assertion failed");

`endif

// ===== src/msfp_pkg.sv =====
// ---------------------------------------------------------------------------
// Motor status frame parser package
// Frame constants, parameter defaults and the decoded result type.
// ---------------------------------------------------------------------------
package msfp_pkg;

  // Frame layout and check values.
  localparam int unsigned FrameLen    = 10;
  localparam logic [7:0]  FrameHeader = 8'h48;
  localparam logic [7:0]  TypeBits    = 8'h0B;

  // Parameter defaults.
  localparam int unsigned DefHistoryDepth = 4;
  localparam int unsigned DefDeviceCount  = 15;

  // Decoded result, device number in the lowest bits.
  typedef struct packed {
    logic signed [31:0] motor_position;
    logic signed [15:0] motor_velocity;
    logic signed [15:0] motor_current;
    logic        [3:0]  device_number;
  } msfp_result_t;

  localparam int unsigned ResultW = $bits(msfp_result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;
  localparam int unsigned OutPadW  = OutDataW - ResultW;

endpackage

// ===== src/motor_status_frame_parser.sv =====
// ---------------------------------------------------------------------------
// Motor status frame parser
// Gathers 10-byte status frames from a byte stream and emits decoded values.
// ---------------------------------------------------------------------------
// The block takes one received byte per cycle. A frame starts with the header
// byte 0x48; any other byte in the first position is dropped. Once ten bytes
// are in, the frame is checked (header, all of type bits 0x0B in the second
// byte, device number 1..DEVICE_COUNT in its upper nibble), the per-device
// current, position and velocity history are updated, and one result item is
// placed in the output register. Bad frames give no item. Throughput is one
// byte per cycle; the input is held off only after a tenth byte, for as long
// as the output register still holds an item not yet taken.
module motor_status_frame_parser #(
  parameter int unsigned HISTORY_DEPTH = msfp_pkg::DefHistoryDepth,
  parameter int unsigned DEVICE_COUNT  = msfp_pkg::DefDeviceCount
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream: tdata [7:0] rx_byte.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,
  // Output stream: tdata [3:0] device_number, [19:4] motor_current,
  // [35:20] motor_velocity, [67:36] motor_position, [71:68] zero.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [msfp_pkg::OutDataW-1:0] m_axis_tdata_o
);

  import msfp_pkg::*;

  `include "motor_status_frame_parser_defines.svh"

  logic [7:0]   frame_q [FrameLen];
  logic [3:0]   byte_count_q, byte_count_d;
  logic         pend_q, pend_d;
  logic         out_valid_q, out_valid_d;
  msfp_result_t result_q, result_d;

  logic         in_fire;
  logic         out_free;
  logic         frame_ok;
  logic         out_load;

  logic [15:0]  current_table_q  [DEVICE_COUNT];
  logic [31:0]  position_table_q [DEVICE_COUNT];
  logic [15:0]  vel_hist_q       [DEVICE_COUNT][HISTORY_DEPTH];

  // Handshake: the output register frees when empty or taken.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !pend_q || out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Byte position: restart on a bad header byte and after the tenth byte.
  always_comb begin
    byte_count_d = byte_count_q;
    pend_d       = pend_q;
    if (pend_q && out_free) begin
      pend_d = 1'b0;
    end
    if (in_fire) begin
      if (byte_count_q == 4'd0) begin
        byte_count_d = (s_axis_tdata_i == FrameHeader) ? 4'd1 : 4'd0;
      end else if (byte_count_q == 4'(FrameLen - 1)) begin
        byte_count_d = 4'd0;
        pend_d       = 1'b1;
      end else begin
        byte_count_d = byte_count_q + 4'd1;
      end
    end
  end

  // Frame byte store, written at the current byte position.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      frame_q[byte_count_q] <= s_axis_tdata_i;
    end
  end

  // Frame check and field decode from the stored bytes.
  always_comb begin
    result_d.device_number  = frame_q[1][7:4];
    result_d.motor_current  = $signed({frame_q[2], frame_q[3]});
    result_d.motor_velocity = $signed({frame_q[4], frame_q[5]});
    result_d.motor_position = $signed({frame_q[6], frame_q[7], frame_q[8], frame_q[9]});
    frame_ok = (frame_q[0] == FrameHeader)
            && ((frame_q[1] & TypeBits) == TypeBits)
            && (result_d.device_number != 4'd0)
            && (result_d.device_number <= 4'(DEVICE_COUNT));
  end

  assign out_load    = pend_q && out_free && frame_ok;
  assign out_valid_d = out_free ? (pend_q && frame_ok) : out_valid_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= 4'd0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OutPadW{1'b0}}, result_q};

  // Per-device tables: current, position and a velocity history that shifts
  // toward older entries as the newest velocity goes into entry 0.
  for (genvar d = 0; d < DEVICE_COUNT; d++) begin : g_dev
    logic dev_wr;
    assign dev_wr = out_load && (result_d.device_number == 4'(d + 1));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        current_table_q[d]  <= '0;
        position_table_q[d] <= '0;
        vel_hist_q[d][0]    <= '0;
      end else if (dev_wr) begin
        current_table_q[d]  <= result_d.motor_current;
        position_table_q[d] <= result_d.motor_position;
        vel_hist_q[d][0]    <= result_d.motor_velocity;
      end
    end

    for (genvar k = 1; k < HISTORY_DEPTH; k++) begin : g_hist
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vel_hist_q[d][k] <= '0;
        end else if (dev_wr) begin
          vel_hist_q[d][k] <= vel_hist_q[d][k-1];
        end
      end
    end
  end

  // Assertions.
  `MSFP_ASSERT_SAME(a_count_range, 1'b1, byte_count_q < 4'(FrameLen))
  `MSFP_ASSERT_SAME(a_pend_count_zero, pend_q, byte_count_q == 4'd0)
  `MSFP_ASSERT_NEXT(a_pend_once, pend_q && out_free, !pend_q)
  `MSFP_ASSERT_NEXT(a_table_update, out_load,
      current_table_q[int'(result_q.device_number) - 1] == result_q.motor_current &&
      position_table_q[int'(result_q.device_number) - 1] == result_q.motor_position &&
      vel_hist_q[int'(result_q.device_number) - 1][0] == result_q.motor_velocity)

endmodule
